FILE: hdl/phm_pkg.sv
// Shared types and constants for the partial horizontal mirror.
// No dependencies; used by every module under hdl/ except phm_ram.
`default_nettype none
package phm_pkg;

    localparam int BYTE_W           = 8;
    localparam int WIDTH_REG_W      = 11;
    localparam int HEIGHT_REG_W     = 13;
    localparam int CHAN_REG_W       = 3;
    localparam int MIRROR_REG_W     = 13;
    localparam int CFG_DATA_W       = 13;
    localparam int CFG_INDEX_W      = 2;
    localparam int ROW_W            = 12;
    localparam int MAX_HEIGHT       = 4096;
    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_MAX_CHANNELS = 4;

    // Output buffer: covers one read in flight plus a stalled receiver.
    localparam int OBUF_DEPTH = 3;
    localparam int OBUF_PTR_W = 2;
    localparam int OBUF_CNT_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_CHANNEL_COUNT = 2'd2,
        CFG_MIRROR_ROWS   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic row_end;
        logic image_end;
    } t_tag;

    // Marks a line buffer read in flight and the flags of its byte.
    typedef struct packed {
        logic valid;
        t_tag tag;
    } t_rd_tag;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        t_tag              tag;
    } t_obuf_ent;

endpackage
`default_nettype wire

FILE: hdl/partial_horizontal_mirror.sv
// Partial horizontal mirror, top level: configuration registers, geometry
// clamping, line buffer RAM, sequencer and output buffer.
// Depends on phm_pkg, phm_ram, phm_seq, phm_obuf.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries interleaved pixel bytes in
//   raster order; i_command = 1 is a flush that stores nothing. Each
//   transaction drains one byte of the previously completed row, if a row is
//   held, on the output channel (o_out_valid / i_out_ready). Rows up to and
//   including mirror_rows come out with pixel order reversed (channel order
//   kept); later rows pass straight. o_row_end / o_image_end flag the last
//   byte of a row / image.
//   Path: a drained byte passes the RAM read register and then the output
//   buffer before it shows on the output channel.
//   Throughput: one transaction per cycle while o_in_ready is high, set by the
//   single write and single read port of the line buffer RAM (both row banks).
//   Stall: a three-entry output buffer absorbs the read in flight; o_in_ready
//   drops only while a row is held and the buffer plus the read in flight are
//   full. With no row held, transactions are always taken.
//   Reset: counters, bank select and held-row state clear; registers take
//   width 1, height 1, channels 1, mirror_rows 0. The RAM is not cleared.
//   Configuration writes take effect at the next cycle; write only when idle.
`default_nettype none
module partial_horizontal_mirror #(
    parameter int MAX_WIDTH    = phm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = phm_pkg::DEF_MAX_CHANNELS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [phm_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [phm_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_command,
    input  wire logic [phm_pkg::BYTE_W-1:0]          i_pixel_byte,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic      [phm_pkg::BYTE_W-1:0]          o_out_byte,
    output logic                                     o_row_end,
    output logic                                     o_image_end
);

    localparam int CW1       = $clog2(MAX_WIDTH + 1);
    localparam int CHW1      = $clog2(MAX_CHANNELS + 1);
    localparam int AW        = $clog2(MAX_WIDTH * MAX_CHANNELS) + 1;
    localparam int RAM_DEPTH = 2 ** AW;
    localparam int HW        = phm_pkg::HEIGHT_REG_W;

    logic [phm_pkg::WIDTH_REG_W-1:0]  r_image_width;
    logic [phm_pkg::HEIGHT_REG_W-1:0] r_image_height;
    logic [phm_pkg::CHAN_REG_W-1:0]   r_channel_count;
    logic [phm_pkg::MIRROR_REG_W-1:0] r_mirror_rows;

    logic [CW1-1:0]  eff_width;
    logic [HW-1:0]   eff_height;
    logic [CHW1-1:0] eff_chan;

    logic                            wr_en, rd_en;
    logic [AW-1:0]                   wr_addr, rd_addr;
    logic [phm_pkg::BYTE_W-1:0]      wr_data, rd_data;
    phm_pkg::t_rd_tag                rd_tag;
    logic [phm_pkg::OBUF_CNT_W-1:0]  buf_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width   <= phm_pkg::WIDTH_REG_W'(1);
            r_image_height  <= phm_pkg::HEIGHT_REG_W'(1);
            r_channel_count <= phm_pkg::CHAN_REG_W'(1);
            r_mirror_rows   <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (phm_pkg::t_cfg_idx'(i_cfg_index))
                phm_pkg::CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_wdata[phm_pkg::WIDTH_REG_W-1:0];
                end
                phm_pkg::CFG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_wdata[phm_pkg::HEIGHT_REG_W-1:0];
                end
                phm_pkg::CFG_CHANNEL_COUNT: begin
                    r_channel_count <= i_cfg_wdata[phm_pkg::CHAN_REG_W-1:0];
                end
                phm_pkg::CFG_MIRROR_ROWS: begin
                    r_mirror_rows <= i_cfg_wdata[phm_pkg::MIRROR_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Zero acts as one; values past the build limits clamp to them.
    always_comb begin
        if (r_image_width == '0) begin
            eff_width = CW1'(1);
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            eff_width = CW1'(MAX_WIDTH);
        end else begin
            eff_width = CW1'(r_image_width);
        end

        if (r_image_height == '0) begin
            eff_height = HW'(1);
        end else if (32'(r_image_height) > phm_pkg::MAX_HEIGHT) begin
            eff_height = HW'(phm_pkg::MAX_HEIGHT);
        end else begin
            eff_height = r_image_height;
        end

        if (r_channel_count == '0) begin
            eff_chan = CHW1'(1);
        end else if (32'(r_channel_count) > MAX_CHANNELS) begin
            eff_chan = CHW1'(MAX_CHANNELS);
        end else begin
            eff_chan = CHW1'(r_channel_count);
        end
    end

    phm_seq #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_pixel_byte  (i_pixel_byte),
        .i_eff_width   (eff_width),
        .i_eff_height  (eff_height),
        .i_eff_chan    (eff_chan),
        .i_mirror_rows (r_mirror_rows),
        .i_buf_count   (buf_count),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .o_rd_tag      (rd_tag)
    );

    phm_ram #(
        .DATA_W (phm_pkg::BYTE_W),
        .DEPTH  (RAM_DEPTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    phm_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (rd_tag),
        .i_push_byte (rd_data),
        .o_count     (buf_count),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_row_end   (o_row_end),
        .o_image_end (o_image_end)
    );

endmodule
`default_nettype wire

FILE: hdl/phm_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module phm_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0]        i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: hdl/phm_obuf.sv
// Three-entry output buffer that catches line buffer read data and feeds
// the valid/ready output channel. Depends on phm_pkg.
`default_nettype none
module phm_obuf (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire phm_pkg::t_rd_tag                 i_push,
    input  wire logic [phm_pkg::BYTE_W-1:0]       i_push_byte,
    output logic      [phm_pkg::OBUF_CNT_W-1:0]   o_count,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic      [phm_pkg::BYTE_W-1:0]       o_out_byte,
    output logic                                  o_row_end,
    output logic                                  o_image_end
);

    localparam int DEPTH = phm_pkg::OBUF_DEPTH;
    localparam int PW    = phm_pkg::OBUF_PTR_W;
    localparam int CNW   = phm_pkg::OBUF_CNT_W;

    phm_pkg::t_obuf_ent r_ent [DEPTH];
    logic [PW-1:0]      r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]      r_rd_ptr, n_rd_ptr;
    logic [CNW-1:0]     r_count, n_count;
    logic               push, pop;

    assign push = i_push.valid;
    assign pop  = o_out_valid && i_out_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CNW'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wr_ptr] <= '{data: i_push_byte, tag: i_push.tag};
        end
    end

    assign o_count     = r_count;
    assign o_out_valid = (r_count != '0);
    assign o_out_byte  = r_ent[r_rd_ptr].data;
    assign o_row_end   = r_ent[r_rd_ptr].tag.row_end;
    assign o_image_end = r_ent[r_rd_ptr].tag.image_end;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_count < CNW'(DEPTH) || pop))
        else $error("output buffer overflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNW'(DEPTH))
        else $error("output buffer count out of range");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> !pop)
        else $error("pop from empty output buffer");

endmodule
`default_nettype wire

FILE: hdl/phm_seq.sv
// Fill and drain sequencer: input/output counters, bank select, mirror
// address generation and the accept decision. Depends on phm_pkg.
`default_nettype none
module phm_seq #(
    parameter int MAX_WIDTH    = phm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = phm_pkg::DEF_MAX_CHANNELS,
    localparam int CW1 = $clog2(MAX_WIDTH + 1),
    localparam int CHW1 = $clog2(MAX_CHANNELS + 1),
    localparam int AW = $clog2(MAX_WIDTH * MAX_CHANNELS) + 1
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic                                 i_command,
    input  wire logic [phm_pkg::BYTE_W-1:0]           i_pixel_byte,
    input  wire logic [CW1-1:0]                       i_eff_width,
    input  wire logic [phm_pkg::HEIGHT_REG_W-1:0]     i_eff_height,
    input  wire logic [CHW1-1:0]                      i_eff_chan,
    input  wire logic [phm_pkg::MIRROR_REG_W-1:0]     i_mirror_rows,
    input  wire logic [phm_pkg::OBUF_CNT_W-1:0]       i_buf_count,
    output logic                                      o_wr_en,
    output logic      [AW-1:0]                        o_wr_addr,
    output logic      [phm_pkg::BYTE_W-1:0]           o_wr_data,
    output logic                                      o_rd_en,
    output logic      [AW-1:0]                        o_rd_addr,
    output phm_pkg::t_rd_tag                          o_rd_tag
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CHW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int LB   = AW - 1;
    localparam int PW   = CW + CHW1 + 1;
    localparam int CMPW = 16;
    localparam int RW   = phm_pkg::ROW_W;
    localparam int OCW  = phm_pkg::OBUF_CNT_W + 1;

    logic [CW-1:0]  r_in_col, n_in_col;
    logic [CHW-1:0] r_in_chan, n_in_chan;
    logic [RW-1:0]  r_in_row, n_in_row;
    logic           r_fill_bank, n_fill_bank;
    logic           r_held_valid, n_held_valid;
    logic           r_held_mirr, n_held_mirr;
    logic           r_held_last, n_held_last;
    logic [CW-1:0]  r_out_col, n_out_col;
    logic [CHW-1:0] r_out_chan, n_out_chan;
    phm_pkg::t_rd_tag r_s1, n_s1;

    logic           acc, emit, store;
    logic           in_last_chan, in_last_col, in_last_row;
    logic           out_last_chan, out_last_col, out_row_end;
    logic [CW-1:0]  rd_col;

    // Byte offset inside one bank: column * channels + channel.
    function automatic logic [LB-1:0] line_offset(input logic [CW-1:0]   col,
                                                  input logic [CHW-1:0]  chan,
                                                  input logic [CHW1-1:0] ch);
        logic [PW-1:0] sum;
        sum = PW'(col) * PW'(ch) + PW'(chan);
        return sum[LB-1:0];
    endfunction

    assign o_in_ready = !r_held_valid ||
                        ((OCW'(i_buf_count) + OCW'(r_s1.valid)) < OCW'(phm_pkg::OBUF_DEPTH));

    assign acc   = i_in_valid && o_in_ready;
    assign emit  = acc && r_held_valid;
    assign store = acc && !i_command;

    assign in_last_chan  = (CMPW'(r_in_chan) + CMPW'(1)) >= CMPW'(i_eff_chan);
    assign in_last_col   = (CMPW'(r_in_col) + CMPW'(1)) >= CMPW'(i_eff_width);
    assign in_last_row   = (CMPW'(r_in_row) + CMPW'(1)) >= CMPW'(i_eff_height);
    assign out_last_chan = (CMPW'(r_out_chan) + CMPW'(1)) >= CMPW'(i_eff_chan);
    assign out_last_col  = (CMPW'(r_out_col) + CMPW'(1)) >= CMPW'(i_eff_width);
    assign out_row_end   = out_last_chan && out_last_col;

    // A drain column past the current width is read straight.
    always_comb begin
        if (r_held_mirr && (CMPW'(r_out_col) < CMPW'(i_eff_width))) begin
            rd_col = CW'(i_eff_width - CW1'(1) - CW1'(r_out_col));
        end else begin
            rd_col = r_out_col;
        end
    end

    assign o_wr_en   = store;
    assign o_wr_addr = {r_fill_bank, line_offset(r_in_col, r_in_chan, i_eff_chan)};
    assign o_wr_data = i_pixel_byte;
    assign o_rd_en   = emit;
    assign o_rd_addr = {~r_fill_bank, line_offset(rd_col, r_out_chan, i_eff_chan)};
    assign o_rd_tag  = r_s1;

    always_comb begin
        n_in_col     = r_in_col;
        n_in_chan    = r_in_chan;
        n_in_row     = r_in_row;
        n_fill_bank  = r_fill_bank;
        n_held_valid = r_held_valid;
        n_held_mirr  = r_held_mirr;
        n_held_last  = r_held_last;
        n_out_col    = r_out_col;
        n_out_chan   = r_out_chan;
        n_s1.valid         = emit;
        n_s1.tag.row_end   = out_row_end;
        n_s1.tag.image_end = out_row_end && r_held_last;

        if (emit) begin
            if (out_last_chan) begin
                n_out_chan = '0;
                if (out_last_col) begin
                    n_out_col    = '0;
                    n_held_valid = 1'b0;
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
            end else begin
                n_out_chan = r_out_chan + CHW'(1);
            end
        end

        // Completing a row overrides whatever remains of the held one.
        if (store) begin
            if (in_last_chan) begin
                n_in_chan = '0;
                if (in_last_col) begin
                    n_in_col     = '0;
                    n_fill_bank  = ~r_fill_bank;
                    n_held_valid = 1'b1;
                    n_held_mirr  = CMPW'(r_in_row) <= CMPW'(i_mirror_rows);
                    n_held_last  = in_last_row;
                    n_out_col    = '0;
                    n_out_chan   = '0;
                    n_in_row     = in_last_row ? '0 : r_in_row + RW'(1);
                end else begin
                    n_in_col = r_in_col + CW'(1);
                end
            end else begin
                n_in_chan = r_in_chan + CHW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col     <= '0;
            r_in_chan    <= '0;
            r_in_row     <= '0;
            r_fill_bank  <= 1'b0;
            r_held_valid <= 1'b0;
            r_held_mirr  <= 1'b0;
            r_held_last  <= 1'b0;
            r_out_col    <= '0;
            r_out_chan   <= '0;
            r_s1         <= '0;
        end else begin
            r_in_col     <= n_in_col;
            r_in_chan    <= n_in_chan;
            r_in_row     <= n_in_row;
            r_fill_bank  <= n_fill_bank;
            r_held_valid <= n_held_valid;
            r_held_mirr  <= n_held_mirr;
            r_held_last  <= n_held_last;
            r_out_col    <= n_out_col;
            r_out_chan   <= n_out_chan;
            r_s1         <= n_s1;
        end
    end

    a_bank_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr_en && o_rd_en) |-> (o_wr_addr[AW-1] != o_rd_addr[AW-1]))
        else $error("fill and drain hit the same bank");

    a_held_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_held_valid) |-> $past(emit && out_row_end))
        else $error("held row released without its last byte");

    a_s1_follows_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_s1.valid)
        else $error("read issued without a tracking tag");

endmodule
`default_nettype wire

FILE: dv/tb_partial_horizontal_mirror.sv
`timescale 1ns / 100ps
// Testbench for partial_horizontal_mirror: streams pixel rows with random gaps and
// stalls, predicts every delayed (mirrored or straight) byte and checks it on the fly.
// Depends on phm_pkg and the RTL under hdl/.
module tb_partial_horizontal_mirror;

    localparam int     CLK_HALF_NS   = 2;
    localparam int     RESET_CYCLES  = 11;
    localparam int     LINE_W        = phm_pkg::DEF_MAX_WIDTH;
    localparam int     LINE_CH       = phm_pkg::DEF_MAX_CHANNELS;
    localparam int     LINE_BYTES    = LINE_W * LINE_CH;
    localparam int     RANDOM_STORES = 800;
    localparam int     SETTLE_CYCLES = 6;
    localparam int     HOLD_CYCLES   = 300;
    localparam longint TIMEOUT_NS    = 4_000_000;
    localparam logic   CMD_STORE     = 1'b0;
    localparam logic   CMD_FLUSH     = 1'b1;

    typedef struct packed {
        logic [phm_pkg::BYTE_W-1:0] data;
        logic                       row_end;
        logic                       image_end;
    } t_out_beat;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_wr_en;
    logic [phm_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [phm_pkg::CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic                            i_command;
    logic [phm_pkg::BYTE_W-1:0]      i_pixel_byte;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic [phm_pkg::BYTE_W-1:0]      o_out_byte;
    logic                            o_row_end;
    logic                            o_image_end;

    // Mirror of the block's registers and row state
    logic [phm_pkg::WIDTH_REG_W-1:0]  geo_width;
    logic [phm_pkg::HEIGHT_REG_W-1:0] geo_height;
    logic [phm_pkg::CHAN_REG_W-1:0]   geo_chans;
    logic [phm_pkg::MIRROR_REG_W-1:0] geo_mirror;
    logic [phm_pkg::BYTE_W-1:0]       row_banks [0:2*LINE_BYTES-1];
    int                               fill_col, fill_chan, fill_row;
    bit                               fill_bank;
    bit                               held_row, held_mirror, held_last;
    int                               drain_col, drain_chan;
    t_out_beat                        beat_q[$];
    t_out_beat                        want_beat;

    int error_count, items_sent, beats_checked, geometries_run;
    int send_gap_pct, recv_gap_pct, recv_hold;

    partial_horizontal_mirror u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_pixel_byte (i_pixel_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_row_end    (o_row_end),
        .o_image_end  (o_image_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout, %0d output bytes still pending", $time, beat_q.size());
        $display("partial_horizontal_mirror verification failed");
        $finish;
    end

    function automatic int cols_now();
        if (geo_width == 0) return 1;
        if (geo_width > LINE_W) return LINE_W;
        return int'(geo_width);
    endfunction

    function automatic int rows_now();
        if (geo_height == 0) return 1;
        if (geo_height > phm_pkg::MAX_HEIGHT) return phm_pkg::MAX_HEIGHT;
        return int'(geo_height);
    endfunction

    function automatic int chans_now();
        if (geo_chans == 0) return 1;
        if (geo_chans > LINE_CH) return LINE_CH;
        return int'(geo_chans);
    endfunction

    function automatic int bank_index(bit bank, int col, int chan, int ch);
        int a;
        a = col * ch + chan;
        if (a >= LINE_BYTES) a = 0;
        return (bank ? LINE_BYTES : 0) + a;
    endfunction

    // One accepted transaction: emit from the held row (if any), then store unless it is a flush.
    function automatic void predict_mirror(logic cmd, logic [phm_pkg::BYTE_W-1:0] pix);
        int        w, h, ch, col;
        bit        last_chan, last_col;
        t_out_beat beat;
        w = cols_now();
        h = rows_now();
        ch = chans_now();
        if (held_row) begin
            col = drain_col;
            last_chan = drain_chan + 1 >= ch;
            last_col = drain_col + 1 >= w;
            if (held_mirror && col < w) col = w - 1 - col;
            beat.data = row_banks[bank_index(!fill_bank, col, drain_chan, ch)];
            beat.row_end = last_chan && last_col;
            beat.image_end = last_chan && last_col && held_last;
            beat_q.push_back(beat);
            if (last_chan) begin
                drain_chan = 0;
                if (last_col) begin
                    drain_col = 0;
                    held_row = 0;
                end else begin
                    drain_col++;
                end
            end else begin
                drain_chan++;
            end
        end
        if (cmd == CMD_STORE) begin
            row_banks[bank_index(fill_bank, fill_col, fill_chan, ch)] = pix;
            if (fill_chan + 1 >= ch) begin
                fill_chan = 0;
                if (fill_col + 1 >= w) begin
                    // row complete: swap banks and hold it for draining
                    fill_col = 0;
                    fill_bank = !fill_bank;
                    held_row = 1;
                    held_mirror = fill_row <= int'(geo_mirror);
                    held_last = fill_row + 1 >= h;
                    drain_col = 0;
                    drain_chan = 0;
                    fill_row = (fill_row + 1 >= h) ? 0 : fill_row + 1;
                end else begin
                    fill_col++;
                end
            end else begin
                fill_chan++;
            end
        end
    endfunction

    // Receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge i_clk) begin
        if (recv_hold > 0) begin
            i_out_ready <= 1'b0;
            recv_hold--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (beat_q.size() == 0) begin
                error_count++;
                $display("%0t: unexpected output byte: expected none, got %02h re %0b ie %0b",
                         $time, o_out_byte, o_row_end, o_image_end);
            end else begin
                want_beat = beat_q.pop_front();
                beats_checked++;
                if (o_out_byte !== want_beat.data) begin
                    error_count++;
                    $display("%0t: out_byte mismatch: expected %02h, got %02h",
                             $time, want_beat.data, o_out_byte);
                end
                if (o_row_end !== want_beat.row_end) begin
                    error_count++;
                    $display("%0t: row_end mismatch: expected %0b, got %0b",
                             $time, want_beat.row_end, o_row_end);
                end
                if (o_image_end !== want_beat.image_end) begin
                    error_count++;
                    $display("%0t: image_end mismatch: expected %0b, got %0b",
                             $time, want_beat.image_end, o_image_end);
                end
            end
        end
    end

    // Entered and left at a falling edge; valid stays high for the next transaction.
    task automatic send_item(input logic cmd, input logic [phm_pkg::BYTE_W-1:0] pix);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_pixel_byte <= pix;
        do @(posedge i_clk); while (!o_in_ready);
        predict_mirror(cmd, pix);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (beat_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input phm_pkg::t_cfg_idx idx, input int value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value[phm_pkg::CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
        case (idx)
            phm_pkg::CFG_IMAGE_WIDTH:   geo_width  = value[phm_pkg::WIDTH_REG_W-1:0];
            phm_pkg::CFG_IMAGE_HEIGHT:  geo_height = value[phm_pkg::HEIGHT_REG_W-1:0];
            phm_pkg::CFG_CHANNEL_COUNT: geo_chans  = value[phm_pkg::CHAN_REG_W-1:0];
            phm_pkg::CFG_MIRROR_ROWS:   geo_mirror = value[phm_pkg::MIRROR_REG_W-1:0];
            default: ;
        endcase
    endtask

    // Drain the held row with flushes so no stale bank entry is read after the change.
    task automatic set_geometry(input int w, input int h, input int ch, input int m);
        while (held_row) send_item(CMD_FLUSH, 8'($urandom));
        wait_for_results();
        write_reg(phm_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(phm_pkg::CFG_IMAGE_HEIGHT, h);
        write_reg(phm_pkg::CFG_CHANNEL_COUNT, ch);
        write_reg(phm_pkg::CFG_MIRROR_ROWS, m);
        geometries_run++;
    endtask

    task automatic send_row(input int flush_pct);
        int row_len;
        row_len = cols_now() * chans_now();
        for (int k = 0; k < row_len; k++) begin
            if ($urandom_range(99) < flush_pct) send_item(CMD_FLUSH, 8'($urandom));
            send_item(CMD_STORE, 8'($urandom));
        end
    endtask

    // Reset geometry is 1x1, one channel, row 0 mirrored; last flush finds nothing held.
    task automatic test_reset_geometry();
        send_item(CMD_STORE, 8'h00);
        send_item(CMD_STORE, 8'hFF);
        send_item(CMD_FLUSH, 8'hA5);
        send_item(CMD_FLUSH, 8'h5A);
    endtask

    // Width 3: middle pixel stays put; row 0 mirrored, row 1 straight, flush mid-row.
    task automatic test_odd_width();
        set_geometry(3, 3, 1, 0);
        send_item(CMD_STORE, 8'h11);
        send_item(CMD_STORE, 8'h22);
        send_item(CMD_STORE, 8'h33);
        send_item(CMD_STORE, 8'h44);
        send_item(CMD_FLUSH, 8'h00);
        send_item(CMD_STORE, 8'h55);
        send_item(CMD_STORE, 8'h66);
    endtask

    // Two pixels of three channels: pixels swap, channel order inside each pixel kept.
    task automatic test_channel_order();
        set_geometry(2, 1, 3, 0);
        send_item(CMD_STORE, 8'h00);
        send_item(CMD_STORE, 8'hFF);
        send_item(CMD_STORE, 8'h01);
        send_item(CMD_STORE, 8'h80);
        send_item(CMD_STORE, 8'h7F);
        send_item(CMD_STORE, 8'hFE);
    endtask

    // Zero registers act as 1; all-ones height and channel registers clamp, all-ones mirror mirrors every row.
    task automatic test_register_extremes();
        set_geometry(0, 0, 0, 0);
        repeat (3) send_row(0);
        set_geometry(8, 13'h1FFF, 1, 13'h1FFF);
        send_row(0);
        set_geometry(2, 2, 7, 1);
        repeat (3) send_row(10);
        set_geometry(5, 13'h1FFF, 13'h1FFF, 0);
        repeat (2) send_row(0);
    endtask

    // Long receiver hold-off while rows keep coming, then a full sender pause.
    task automatic test_backpressure();
        int saved_gap;
        saved_gap = send_gap_pct;
        set_geometry(4, 3, 3, 1);
        send_gap_pct = 0;
        recv_hold = HOLD_CYCLES;
        repeat (4) send_row(0);
        wait_for_results();
        repeat (2) send_row(5);
        send_gap_pct = saved_gap;
    endtask

    task automatic test_random_images();
        int stores_done, w, h, ch, m, rows, row_len;
        stores_done = 0;
        while (stores_done < RANDOM_STORES) begin
            if (stores_done < RANDOM_STORES / 3) begin
                send_gap_pct = 21;
                recv_gap_pct = 75;
            end else if (stores_done < 2 * RANDOM_STORES / 3) begin
                send_gap_pct = 75;
                recv_gap_pct = 21;
            end else begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            w = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            h = ($urandom_range(19) == 0) ? 13'h1FFF : $urandom_range(0, 6);
            ch = $urandom_range(0, 7);
            m = ($urandom_range(19) == 0) ? 13'h1FFF : $urandom_range(0, 7);
            set_geometry(w, h, ch, m);
            rows = $urandom_range(1, 2 * rows_now() + 1);
            if (rows > 12) rows = 12;
            row_len = cols_now() * chans_now();
            for (int r = 0; r < rows; r++) begin
                send_row(($urandom_range(3) == 0) ? 20 : 0);
                stores_done += row_len;
                if ($urandom_range(15) == 0) wait_for_results();
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_wr_en  = 1'b0;
        i_cfg_index  = phm_pkg::CFG_IMAGE_WIDTH;
        i_cfg_wdata  = '0;
        i_in_valid   = 1'b0;
        i_command    = CMD_STORE;
        i_pixel_byte = '0;
        geo_width    = 1;
        geo_height   = 1;
        geo_chans    = 1;
        geo_mirror   = 0;
        fill_col     = 0;
        fill_chan    = 0;
        fill_row     = 0;
        fill_bank    = 0;
        held_row     = 0;
        held_mirror  = 0;
        held_last    = 0;
        drain_col    = 0;
        drain_chan   = 0;
        error_count  = 0;
        items_sent   = 0;
        beats_checked = 0;
        geometries_run = 1;
        send_gap_pct = 21;
        recv_gap_pct = 75;
        recv_hold    = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_geometry();
        test_odd_width();
        test_channel_order();
        test_register_extremes();
        test_backpressure();
        test_random_images();

        while (held_row) send_item(CMD_FLUSH, 8'($urandom));
        wait_for_results();

        $display("Sent %0d transactions and checked %0d output bytes over %0d geometries,",
                 items_sent, beats_checked, geometries_run);
        $display("with mirrored and straight rows, flushes, clamped registers and stalls.");
        if (error_count == 0) begin
            $display("partial_horizontal_mirror verification clean");
        end else begin
            $display("%0d mismatches found", error_count);
            $display("partial_horizontal_mirror verification failed");
        end
        $finish;
    end

endmodule
